// ===== rtl/button_click_classifier_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps
package bcc_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int TIMER_BITS         = 17;
    localparam int CFG_DATA_BITS      = 16;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int TOTAL_BITS         = 32;

    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [CFG_DATA_BITS-1:0] WINDOW_RESET   = 16'd300;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE_MS = 1'b0,
        CFG_WINDOW_MS   = 1'b1
    } t_cfg_index;

    typedef logic [TIMER_BITS-1:0] t_timer;

    typedef struct packed {
        logic                  pressed;
        logic                  single_click;
        logic                  double_click;
        logic [TOTAL_BITS-1:0] single_total;
        logic [TOTAL_BITS-1:0] double_total;
    } t_result;

endpackage

// ===== rtl/button_click_classifier.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+--------------------------------------
// in       | sink      | i_in_valid / o_in_stall | i_pin_level, i_clear_counts
// out      | source    | o_out_valid / i_out_stall | o_pressed, o_single_click,
//          |           |                        | o_double_click, o_single_total,
//          |           |                        | o_double_total
// cfg      | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One tick per clock while o_in_stall is low: a tick's state update completes
// in the cycle it is accepted, and its result is registered in the two-entry
// output queue (result register plus skid register), which keeps input
// accepted while one result waits; o_in_stall rises only when both are full.
// Synchronous active-low reset clears all state and loads the default timings.
// Configuration writes are taken in any cycle (o_cfg_ready is always high).
module button_click_classifier #(
    parameter int COUNT_BITS = bcc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_pin_level,
    input  logic                               i_clear_counts,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_pressed,
    output logic                               o_single_click,
    output logic                               o_double_click,
    output logic [bcc_pkg::TOTAL_BITS-1:0]     o_single_total,
    output logic [bcc_pkg::TOTAL_BITS-1:0]     o_double_total,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bcc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [bcc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import bcc_pkg::*;

    localparam t_timer TIMER_MAX = '1;

    logic [CFG_DATA_BITS-1:0] r_debounce_ms;
    logic [CFG_DATA_BITS-1:0] r_window_ms;

    logic                  r_last_raw,     n_last_raw;
    logic                  r_stable,       n_stable;
    logic                  r_prior,        n_prior;
    logic                  r_db_running,   n_db_running;
    t_timer                r_db_elapsed,   n_db_elapsed;
    logic                  r_awaiting,     n_awaiting;
    t_timer                r_click_elapsed, n_click_elapsed;
    logic [COUNT_BITS-1:0] r_single_count, n_single_count;
    logic [COUNT_BITS-1:0] r_double_count, n_double_count;

    t_result res;
    t_result r_head;
    t_result r_skid;
    logic    r_head_valid;
    logic    r_skid_valid;

    logic raw;
    logic in_acc;
    logic out_pop;
    logic [COUNT_BITS-1:0] single_base;
    logic [COUNT_BITS-1:0] double_base;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_acc      = i_in_valid && !r_skid_valid;
    assign out_pop     = r_head_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
            r_window_ms   <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_MS: r_debounce_ms <= i_cfg_data;
                CFG_WINDOW_MS:   r_window_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        raw = !i_pin_level;

        single_base = i_clear_counts ? '0 : r_single_count;
        double_base = i_clear_counts ? '0 : r_double_count;
        n_single_count = single_base;
        n_double_count = double_base;

        // advance both timers, saturating at all ones
        n_db_elapsed = r_db_elapsed;
        if (r_db_running && r_db_elapsed != TIMER_MAX) begin
            n_db_elapsed = r_db_elapsed + 1'b1;
        end
        n_click_elapsed = r_click_elapsed;
        if (r_awaiting && r_click_elapsed != TIMER_MAX) begin
            n_click_elapsed = r_click_elapsed + 1'b1;
        end

        // any raw change restarts the debounce timer
        n_last_raw   = r_last_raw;
        n_db_running = r_db_running;
        if (raw != r_last_raw) begin
            n_last_raw   = raw;
            n_db_running = 1'b1;
            n_db_elapsed = '0;
        end

        n_prior  = r_prior;
        n_stable = r_stable;
        if (n_db_running && n_db_elapsed >= TIMER_BITS'(r_debounce_ms)) begin
            n_db_running = 1'b0;
            n_prior      = r_stable;
            n_stable     = raw;
        end

        res.single_click = 1'b0;
        res.double_click = 1'b0;
        n_awaiting       = r_awaiting;
        if (n_stable && !n_prior) begin
            n_prior = 1'b1;
            if (r_awaiting && n_click_elapsed <= TIMER_BITS'(r_window_ms)) begin
                n_double_count   = double_base + COUNT_BITS'(1);
                res.double_click = 1'b1;
                n_awaiting       = 1'b0;
            end else begin
                n_awaiting      = 1'b1;
                n_click_elapsed = '0;
            end
        end

        // window ran out with no second click
        if (n_awaiting && n_click_elapsed > TIMER_BITS'(r_window_ms)) begin
            n_single_count   = single_base + COUNT_BITS'(1);
            res.single_click = 1'b1;
            n_awaiting       = 1'b0;
        end

        res.pressed      = n_stable;
        res.single_total = TOTAL_BITS'(n_single_count);
        res.double_total = TOTAL_BITS'(n_double_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw      <= 1'b0;
            r_stable        <= 1'b0;
            r_prior         <= 1'b0;
            r_db_running    <= 1'b0;
            r_db_elapsed    <= '0;
            r_awaiting      <= 1'b0;
            r_click_elapsed <= '0;
            r_single_count  <= '0;
            r_double_count  <= '0;
        end else if (in_acc) begin
            r_last_raw      <= n_last_raw;
            r_stable        <= n_stable;
            r_prior         <= n_prior;
            r_db_running    <= n_db_running;
            r_db_elapsed    <= n_db_elapsed;
            r_awaiting      <= n_awaiting;
            r_click_elapsed <= n_click_elapsed;
            r_single_count  <= n_single_count;
            r_double_count  <= n_double_count;
        end
    end

    // result register with a skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_pop || !r_head_valid) begin
                if (r_skid_valid) begin
                    r_head_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_head_valid <= in_acc;
                end
            end else if (in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_pop || !r_head_valid) begin
            r_head <= r_skid_valid ? r_skid : res;
        end else if (in_acc) begin
            r_skid <= res;
        end
    end

    assign o_out_valid    = r_head_valid;
    assign o_pressed      = r_head.pressed;
    assign o_single_click = r_head.single_click;
    assign o_double_click = r_head.double_click;
    assign o_single_total = r_head.single_total;
    assign o_double_total = r_head.double_total;

endmodule

// ===== rtl/bcc_checker.sv =====
`timescale 1ns / 1ps
`include "button_click_classifier_assert.svh"
module bcc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               i_pin_level,
    input logic                               i_clear_counts,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_pressed,
    input logic                               o_single_click,
    input logic                               o_double_click,
    input logic [bcc_pkg::TOTAL_BITS-1:0]     o_single_total,
    input logic [bcc_pkg::TOTAL_BITS-1:0]     o_double_total,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [bcc_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input logic [bcc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import bcc_pkg::*;

    t_result out_word;
    logic    unused_inputs;

    assign out_word = '{pressed: o_pressed, single_click: o_single_click,
                        double_click: o_double_click, single_total: o_single_total,
                        double_total: o_double_total};
    assign unused_inputs = ^{i_pin_level, i_clear_counts, i_cfg_valid, o_cfg_ready,
                             i_cfg_index, i_cfg_data};

    // a tick classifies as single or double, never both
    `BCC_ASSERT_NOW(a_click_exclusive, o_out_valid, !(o_single_click && o_double_click), "single and double click in one transaction")

    // input backs up only behind a waiting result
    `BCC_ASSERT_NOW(a_stall_needs_result, o_in_stall, o_out_valid, "input stalled with no result pending")

    // one stalled result plus a new transaction fills the skid entry
    `BCC_ASSERT_NEXT(a_skid_fills, o_out_valid && i_out_stall && i_in_valid && !o_in_stall, o_in_stall, "skid entry not filled")

    // a stalled result holds
    `BCC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_word), "stalled result changed")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_pin_level    (i_pin_level),
    .i_clear_counts (i_clear_counts),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pressed      (o_pressed),
    .o_single_click (o_single_click),
    .o_double_click (o_double_click),
    .o_single_total (o_single_total),
    .o_double_total (o_double_total),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready),
    .i_cfg_index    (i_cfg_index),
    .i_cfg_data     (i_cfg_data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import bcc_pkg::*;

    localparam int  CLK_PERIOD = 12;
    localparam int  LIMIT_CYCLES = 200_000;
    localparam int  PRINT_CAP = 40;
    localparam int  HOLD_AFTER = 120;
    localparam int  HOLD_CYCLES = 80;
    localparam logic PIN_DOWN = 1'b0;
    localparam logic PIN_UP = 1'b1;

    typedef struct packed {
        logic pin;
        logic clear;
    } t_tick;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_pin = PIN_UP;
    logic in_clear = 1'b0;
    logic o_in_stall;

    logic o_out_valid;
    logic out_stall;
    logic o_pressed;
    logic o_single_click;
    logic o_double_click;
    logic [TOTAL_BITS-1:0] o_single_total;
    logic [TOTAL_BITS-1:0] o_double_total;

    logic cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    button_click_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_pin_level    (in_pin),
        .i_clear_counts (in_clear),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_pressed      (o_pressed),
        .o_single_click (o_single_click),
        .o_double_click (o_double_click),
        .o_single_total (o_single_total),
        .o_double_total (o_double_total),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Click predictor state
    logic [CFG_DATA_BITS-1:0] cur_debounce = DEBOUNCE_RESET;
    logic [CFG_DATA_BITS-1:0] cur_window = WINDOW_RESET;
    logic seen_raw = 1'b0;
    logic level = 1'b0;
    logic level_prev = 1'b0;
    logic settling = 1'b0;
    t_timer settle_age = '0;
    logic waiting_second = 1'b0;
    t_timer gap_age = '0;
    logic [TOTAL_BITS-1:0] singles = '0;
    logic [TOTAL_BITS-1:0] doubles = '0;

    t_tick stim_ticks[$];
    t_result click_reports[$];

    bit quiet = 1'b0;
    int send_gap = 0;
    int rx_wait = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int ticks_sent = 0;
    int reports_seen = 0;
    int n_fail = 0;
    int settings_used = 0;
    int singles_seen = 0;
    int doubles_seen = 0;

    function automatic t_timer age_tick(input t_timer v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic classify_tick(input logic pin, input logic clr);
        logic raw;
        t_result r;
        raw = ~pin;
        r = '0;
        if (clr) begin
            singles = '0;
            doubles = '0;
        end
        if (settling) settle_age = age_tick(settle_age);
        if (waiting_second) gap_age = age_tick(gap_age);
        if (raw != seen_raw) begin
            seen_raw = raw;
            settling = 1'b1;
            settle_age = '0;
        end
        if (settling && settle_age >= t_timer'(cur_debounce)) begin
            settling = 1'b0;
            level_prev = level;
            level = raw;
        end
        // rising edge of the debounced level is a click
        if (level && !level_prev) begin
            level_prev = 1'b1;
            if (waiting_second && gap_age <= t_timer'(cur_window)) begin
                doubles = doubles + 1'b1;
                r.double_click = 1'b1;
                waiting_second = 1'b0;
                doubles_seen++;
            end else begin
                waiting_second = 1'b1;
                gap_age = '0;
            end
        end
        if (waiting_second && gap_age > t_timer'(cur_window)) begin
            singles = singles + 1'b1;
            r.single_click = 1'b1;
            waiting_second = 1'b0;
            singles_seen++;
        end
        r.pressed = level;
        r.single_total = singles;
        r.double_total = doubles;
        click_reports.push_back(r);
    endtask

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            if (n_fail < PRINT_CAP)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Driver: one tick per transaction, random gap after each unless quiet
    always @(posedge i_clk) begin
        logic v;
        int g;
        t_tick t;
        v = in_valid;
        g = send_gap;
        t.pin = in_pin;
        t.clear = in_clear;
        if (!rst_n) begin
            v = 1'b0;
            g = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                classify_tick(in_pin, in_clear);
                ticks_sent++;
                v = 1'b0;
                g = quiet ? 0 : $urandom_range(0, 10);
            end
            if (!v) begin
                if (g > 0) begin
                    g--;
                end else if (stim_ticks.size() != 0) begin
                    t = stim_ticks.pop_front();
                    v = 1'b1;
                end
            end
        end
        in_valid <= v;
        send_gap <= g;
        in_pin <= t.pin;
        in_clear <= t.clear;
    end

    assign out_stall = (rx_wait != 0) || (hold_left != 0);

    // Receiver: random stall after each transaction unless quiet
    always @(posedge i_clk) begin
        int w;
        w = rx_wait;
        if (!rst_n) begin
            w = 0;
        end else if (o_out_valid && !out_stall) begin
            w = quiet ? 0 : $urandom_range(0, 10);
        end else if (w > 0) begin
            w--;
        end
        rx_wait <= w;
    end

    // One long hold-off so the output queue fills and the input stalls
    always @(posedge i_clk) begin
        if (!hold_done && reports_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_result want;
        int bad;
        if (rst_n && o_out_valid && !out_stall) begin
            reports_seen++;
            if (click_reports.size() == 0) begin
                if (n_fail < PRINT_CAP)
                    $display("%0t: result with none expected, actual single_total %0h",
                             $time, o_single_total);
                n_fail++;
            end else begin
                want = click_reports.pop_front();
                bad = field_differs("pressed", 32'(want.pressed), 32'(o_pressed))
                    + field_differs("single_click", 32'(want.single_click),
                                    32'(o_single_click))
                    + field_differs("double_click", 32'(want.double_click),
                                    32'(o_double_click))
                    + field_differs("single_total", want.single_total, o_single_total)
                    + field_differs("double_total", want.double_total, o_double_total);
                if (bad != 0) n_fail++;
            end
        end
    end

    task automatic push_tick(input logic pin, input logic clr);
        t_tick t;
        t.pin = pin;
        t.clear = clr;
        stim_ticks.push_back(t);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (stim_ticks.size() != 0 || in_valid || click_reports.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEBOUNCE_MS: cur_debounce = val;
            CFG_WINDOW_MS:   cur_window = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [CFG_DATA_BITS-1:0] deb,
                              input logic [CFG_DATA_BITS-1:0] win);
        write_reg(CFG_DEBOUNCE_MS, deb);
        write_reg(CFG_WINDOW_MS, win);
        settings_used++;
    endtask

    // Presses and releases held around the debounce time and the window,
    // mixed with short bounces and pure noise
    task automatic queue_presses(input int n_ticks);
        int deb_cap;
        int win_cap;
        int seg;
        int left;
        int kind;
        logic lvl;
        deb_cap = (cur_debounce > 40) ? 40 : int'(cur_debounce);
        win_cap = (cur_window > 40) ? 40 : int'(cur_window);
        left = n_ticks;
        lvl = PIN_UP;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            lvl = ~lvl;
            if (kind == 0)
                seg = $urandom_range(1, 6);
            else if (kind < 3)
                seg = $urandom_range(1, deb_cap + 1);
            else
                seg = deb_cap + $urandom_range(1, win_cap + 4);
            if (seg > left) seg = left;
            repeat (seg)
                push_tick(kind == 0 ? logic'($urandom_range(0, 1)) : lvl,
                          $urandom_range(0, 24) == 0);
            left -= seg;
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_BITS-1:0] deb,
                             input logic [CFG_DATA_BITS-1:0] win, input int n_ticks);
        set_timing(deb, win);
        quiet = ($urandom_range(0, 3) == 0);
        queue_presses(n_ticks);
        wait_idle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // reset timings: a bounce too short to latch, with a clear
        push_tick(PIN_UP, 1'b0);
        push_tick(PIN_DOWN, 1'b1);
        push_tick(PIN_UP, 1'b0);
        wait_idle();

        // zero debounce, zero window: every click confirms as single next tick
        set_timing('0, '0);
        push_tick(PIN_DOWN, 1'b0);
        push_tick(PIN_UP, 1'b0);
        push_tick(PIN_DOWN, 1'b0);
        push_tick(PIN_UP, 1'b0);
        push_tick(PIN_UP, 1'b0);
        wait_idle();

        // window of two: double click, a click right after expiry, then a single click
        set_timing('0, 16'd2);
        push_tick(PIN_DOWN, 1'b0);
        push_tick(PIN_UP, 1'b0);
        push_tick(PIN_DOWN, 1'b0);
        repeat (4) push_tick(PIN_UP, 1'b0);
        push_tick(PIN_DOWN, 1'b0);
        push_tick(PIN_UP, 1'b0);
        push_tick(PIN_UP, 1'b0);
        push_tick(PIN_DOWN, 1'b0);
        push_tick(PIN_UP, 1'b1);
        repeat (3) push_tick(PIN_UP, 1'b0);
        wait_idle();

        run_phase('0, '1, 30);
        run_phase('1, '0, 30);
        run_phase(16'd1, 16'd3, 70);
        run_phase(16'd2, 16'd7, 70);
        repeat (3) run_phase(CFG_DATA_BITS'($urandom_range(0, 8)),
                             CFG_DATA_BITS'($urandom_range(0, 40)), 70);
        run_phase(DEBOUNCE_RESET, WINDOW_RESET, 100);

        repeat (20) @(posedge i_clk);
        $display("Applied %0d ticks across %0d timing settings, zero and full scale included;",
                 ticks_sent, settings_used);
        $display("predicted %0d single and %0d double clicks, checked %0d results.",
                 singles_seen, doubles_seen, reports_seen);
        if (n_fail == 0)
            $display("button_click_classifier test passed");
        else
            $display("button_click_classifier test failed");
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results outstanding", click_reports.size());
        $display("button_click_classifier test failed");
        $finish;
    end

endmodule

// ===== button_click_classifier.f =====
+incdir+rtl
rtl/bcc_pkg.sv
rtl/button_click_classifier.sv
rtl/bcc_checker.sv
tb/tb_top.sv
